// File: src/interval_reservation_admission_macros.svh
// ----------------------------------------------------------------------------
// Interval reservation admission assertion macros
// Shared concurrent assertion wrappers. They compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_RESERVATION_ADMISSION_MACROS_SVH
`define INTERVAL_RESERVATION_ADMISSION_MACROS_SVH
`ifndef SYNTHESIS
// Clocked assertion that is held off while reset is asserted.
`define IRAD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define IRAD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IRAD_ASSERT(label, prop, msg)
`define IRAD_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// File: src/irad_pkg.sv
// ----------------------------------------------------------------------------
// Interval reservation admission package
// Shared widths, register indexes and controller/datapath signal groups.
// ----------------------------------------------------------------------------
`default_nettype none
package irad_pkg;
	localparam int FIELD_W       = 11;
	localparam int CNT_W         = 4;
	localparam int SLOTS_DEFAULT = 1024;
	localparam int PADDR_W       = 3;
	localparam int PDATA_W       = 32;
	localparam logic [CNT_W-1:0] CAPACITY_RESET = 4'd2;

	// Register indexes.
	localparam logic REG_CAPACITY = 1'b0;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr;     // write zero at the pointer and step it
		logic load;    // capture the clamped interval
		logic rd;      // read the slot at the pointer and step it
		logic upd;     // reads of this pass are incremented and written back
		logic rewind;  // pointer back to the start of the interval
		logic emit;    // load the result register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;     // captured interval is empty
		logic last;      // pointer is on the final slot of the interval
		logic clr_last;  // pointer is on the final slot of the store
		logic admit;     // peak is below capacity
	} status_t;
endpackage
`default_nettype wire

// File: src/irad_if.sv
// ----------------------------------------------------------------------------
// Interval reservation admission channels
// Request and response channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface irad_req_if;
	logic                         valid;
	logic                         ready;
	logic [irad_pkg::FIELD_W-1:0] range_start;
	logic [irad_pkg::FIELD_W-1:0] range_end;
	modport source (output valid, output range_start, output range_end, input ready);
	modport sink (input valid, input range_start, input range_end, output ready);
endinterface

interface irad_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       accepted;
	logic [irad_pkg::CNT_W-1:0] peak_overlap;
	modport source (output valid, output accepted, output peak_overlap, input ready);
	modport sink (input valid, input accepted, input peak_overlap, output ready);
endinterface
`default_nettype wire

// File: src/interval_reservation_admission.sv
// One request is in flight at a time; a new request can be taken in the cycle after the
// result is registered. The occupancy RAM is read one slot per cycle in each pass.
// Reset (arst_n low, asynchronous) sets capacity to 2 and starts a clearing pass that
// zeroes the occupancy store; no request is taken until it ends.
// ----------------------------------------------------------------------------
// Interval reservation admission
// Admits a slot interval reservation when its peak occupancy is below capacity.
// ----------------------------------------------------------------------------
`default_nettype none
module interval_reservation_admission #(
	parameter int SLOTS = irad_pkg::SLOTS_DEFAULT
) (
	input  wire                          clk,
	input  wire                          arst_n,
	irad_req_if.sink                     req,
	irad_rsp_if.source                   rsp,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [irad_pkg::PADDR_W-1:0]  paddr,
	input  wire [irad_pkg::PDATA_W-1:0]  pwdata,
	output logic [irad_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);
	import irad_pkg::*;

	// The capacity register is the only configuration state. Writes to any other
	// word address are dropped, and reads of them return zero.
	logic [CNT_W-1:0] capacity_q;
	logic             reg_idx;
	cmd_t             cmd;
	status_t          st;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (psel && penable && pwrite && pready && (reg_idx == REG_CAPACITY)) begin
			capacity_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = (reg_idx == REG_CAPACITY) ? PDATA_W'(capacity_q) : '0;

	// The controller walks each request through a scan pass that finds the
	// highest occupancy over the interval and, when the request is admitted,
	// an update pass that adds one to every slot of it.
	irad_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.st        (st),
		.cmd       (cmd)
	);

	// The datapath holds one occupancy count per slot and the result register,
	// so a finished result can wait while the next request is taken.
	irad_datapath #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.range_start  (req.range_start),
		.range_end    (req.range_end),
		.capacity     (capacity_q),
		.accepted     (rsp.accepted),
		.peak_overlap (rsp.peak_overlap)
	);
endmodule
`default_nettype wire

// File: src/irad_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module irad_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 1024
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire [$clog2(DEPTH)-1:0]   waddr,
	input  wire [WIDTH-1:0]           wdata,
	input  wire [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: src/irad_datapath.sv
// ----------------------------------------------------------------------------
// Interval reservation admission datapath
// Slot pointer, occupancy store, peak accumulation and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module irad_datapath #(
	parameter int SLOTS = 1024
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  irad_pkg::cmd_t               cmd,
	output irad_pkg::status_t            st,
	input  wire [irad_pkg::FIELD_W-1:0]  range_start,
	input  wire [irad_pkg::FIELD_W-1:0]  range_end,
	input  wire [irad_pkg::CNT_W-1:0]    capacity,
	output logic                         accepted,
	output logic [irad_pkg::CNT_W-1:0]   peak_overlap
);
	import irad_pkg::*;

	localparam int AW = $clog2(SLOTS);
	localparam int PW = $clog2(SLOTS + 1);
	localparam int CW = (PW > FIELD_W) ? PW : FIELD_W;

	logic [PW-1:0]    ptr_q, start_q, end_q;
	logic [CNT_W-1:0] peak_q;
	logic             empty_q;
	logic             rd_s1, upd_s1;
	logic [AW-1:0]    addr_s1;
	logic [CNT_W-1:0] rdata;
	logic [CW-1:0]    start_w, end_w, start_c, end_c;
	logic             we;
	logic [AW-1:0]    waddr;
	logic [CNT_W-1:0] wdata;

	// Bounds past the last slot are pulled in to the slot count.
	always_comb begin
		start_w = CW'(range_start);
		end_w   = CW'(range_end);
		start_c = (start_w > CW'(SLOTS)) ? CW'(SLOTS) : start_w;
		end_c   = (end_w > CW'(SLOTS)) ? CW'(SLOTS) : end_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			rd_s1  <= 1'b0;
			upd_s1 <= 1'b0;
		end else begin
			rd_s1  <= cmd.rd;
			upd_s1 <= cmd.upd;
			if (cmd.load) begin
				ptr_q <= PW'(start_c);
			end else if (cmd.rewind) begin
				ptr_q <= start_q;
			end else if (cmd.clr || cmd.rd) begin
				ptr_q <= ptr_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= ptr_q[AW-1:0];
		if (cmd.load) begin
			start_q <= PW'(start_c);
			end_q   <= PW'(end_c);
			empty_q <= (end_c <= start_c);
			peak_q  <= '0;
		end else if (rd_s1 && !upd_s1 && (rdata > peak_q)) begin
			peak_q <= rdata;
		end
		if (cmd.emit) begin
			accepted     <= empty_q | st.admit;
			peak_overlap <= peak_q;
		end
	end

	// Scan reads fold into the peak; update reads come back incremented.
	always_comb begin
		we    = cmd.clr | (rd_s1 & upd_s1);
		waddr = cmd.clr ? ptr_q[AW-1:0] : addr_s1;
		wdata = cmd.clr ? '0 : rdata + CNT_W'(1);
	end

	irad_ram #(
		.WIDTH (CNT_W),
		.DEPTH (SLOTS)
	) u_occupancy (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (ptr_q[AW-1:0]),
		.rdata (rdata)
	);

	always_comb begin
		st.empty    = empty_q;
		st.last     = (ptr_q == end_q - PW'(1));
		st.clr_last = (ptr_q == PW'(SLOTS - 1));
		st.admit    = (peak_q < capacity);
	end
endmodule
`default_nettype wire

// File: src/irad_controller.sv
// ----------------------------------------------------------------------------
// Interval reservation admission controller
// Sequences the clearing pass, the peak scan, the update pass and the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "interval_reservation_admission_macros.svh"
module irad_controller (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire                out_ready,
	input  irad_pkg::status_t  st,
	output irad_pkg::cmd_t     cmd
);
	import irad_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_CHECK, S_SCAN, S_DRAIN, S_DECIDE, S_UPD, S_UDRAIN, S_RESP
	} state_t;

	state_t state_q;
	logic   out_free;

	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid || out_ready;

	always_comb begin
		cmd        = '0;
		cmd.clr    = (state_q == S_CLEAR);
		cmd.load   = in_ready && in_valid;
		cmd.rd     = (state_q == S_SCAN) || (state_q == S_UPD);
		cmd.upd    = (state_q == S_UPD);
		cmd.rewind = (state_q == S_DECIDE) && st.admit;
		cmd.emit   = (state_q == S_RESP) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			out_valid <= 1'b0;
		end else begin
			if ((state_q == S_RESP) && out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (st.clr_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) state_q <= S_CHECK;
				end
				S_CHECK: begin
					state_q <= st.empty ? S_RESP : S_SCAN;
				end
				S_SCAN: begin
					if (st.last) state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					state_q <= st.admit ? S_UPD : S_RESP;
				end
				S_UPD: begin
					if (st.last) state_q <= S_UDRAIN;
				end
				S_UDRAIN: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	`IRAD_ASSERT(a_no_scan_empty, (state_q == S_SCAN) |-> !st.empty, "scan of an empty interval")
	`IRAD_ASSERT(a_upd_admitted, $rose(state_q == S_UPD) |-> $past(st.admit), "update without admission")
	`IRAD_ASSERT(a_clr_excl, !(cmd.clr && (cmd.load || cmd.emit)), "request during clearing")
endmodule
`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Interval reservation admission testbench
// Drives interval requests through the request channel and checks every
// response against a per-slot occupancy predictor or a row's fixed outcome.
// The run starts with a table of hand-picked requests and continues with
// random requests under several capacity settings. Both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
	import irad_pkg::*;

	localparam int SLOTS      = SLOTS_DEFAULT;
	localparam int HOLD_LEN   = 400;
	localparam int STALL_MAX  = 40000;
	localparam logic [PADDR_W-1:0] CAPACITY_ADDR = PADDR_W'(REG_CAPACITY) << 2;
	// Address one word past the only register; writes there must be ignored.
	localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = CAPACITY_ADDR + PADDR_W'(4);

	typedef logic [FIELD_W-1:0] slot_t;
	typedef logic [CNT_W-1:0]   cnt_t;

	typedef struct packed {
		logic accepted;
		cnt_t peak_overlap;
	} verdict_t;

	// One row of the directed table. A row either reprograms the capacity
	// (with the block idle) or sends one request. Rows whose outcome is plain
	// carry it here; the others rely on the occupancy predictor.
	typedef struct packed {
		logic     set_cap;
		cnt_t     cap;
		slot_t    range_start;
		slot_t    range_end;
		logic     fixed;
		verdict_t outcome;
	} row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	irad_req_if req_ch();
	irad_rsp_if rsp_ch();

	interval_reservation_admission #(.SLOTS(SLOTS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Predictor state: the occupancy of every slot and the capacity that the
	// block should be using. A segment tree with lazy adds holds the same
	// per-slot counts, so a flat array gives the same peaks.
	cnt_t     slot_load [SLOTS];
	cnt_t     cap_now;
	verdict_t pending_verdicts [$];
	int       errors;
	logic     hold_request;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Clamp both bounds to the slot count, take the peak over the interval
	// and, when it is below capacity, count the reservation in every slot.
	function automatic verdict_t admit_interval(slot_t s_in, slot_t e_in);
		int       s;
		int       e;
		verdict_t v;
		s = (s_in > SLOTS) ? SLOTS : int'(s_in);
		e = (e_in > SLOTS) ? SLOTS : int'(e_in);
		v.accepted     = 1'b1;
		v.peak_overlap = '0;
		if (e <= s)
			return v;
		for (int i = s; i < e; i++)
			if (slot_load[i] > v.peak_overlap)
				v.peak_overlap = slot_load[i];
		if (v.peak_overlap >= cap_now) begin
			v.accepted = 1'b0;
			return v;
		end
		for (int i = s; i < e; i++)
			slot_load[i] = slot_load[i] + 1'b1;
		return v;
	endfunction

	// APB write: a setup phase, then an access phase; pready is always high.
	task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == CAPACITY_ADDR)
			cap_now = cnt_t'(data);
	endtask

	// Offer one request after a random gap and wait until it is taken. The
	// valid line is left high so back-to-back requests need not drop it.
	task automatic send_request(slot_t s, slot_t e, logic fixed, verdict_t outcome);
		int       gap;
		verdict_t v;
		gap = $urandom_range(0, 7);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.range_start <= s;
		req_ch.range_end   <= e;
		do
			@(posedge clk);
		while (!req_ch.ready);
		v = admit_interval(s, e);
		pending_verdicts.push_back(fixed ? outcome : v);
	endtask

	// Drop valid and wait for every outstanding response, so a register may
	// be written with the block idle. Every request yields one response.
	task automatic drain;
		req_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	// Mostly short intervals so the run stays quick, some long ones, and a
	// share of raw 11-bit bounds that land past the slots or empty.
	task automatic random_request;
		slot_t s;
		slot_t e;
		int    pick;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			s = slot_t'($urandom);
			e = slot_t'($urandom);
		end else if (pick < 16) begin
			s = slot_t'($urandom_range(0, SLOTS / 4));
			e = slot_t'($urandom_range(SLOTS / 2, SLOTS));
		end else begin
			s = slot_t'($urandom_range(0, SLOTS - 1));
			e = s + slot_t'($urandom_range(1, 16));
		end
		send_request(s, e, 1'b0, '0);
	endtask

	// Response side: random stalls, plus one long hold-off when asked so the
	// block backs up and refuses further requests on its input.
	initial begin
		int       stall;
		verdict_t want;
		rsp_ch.ready = 1'b0;
		forever begin
			if (hold_request) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
				hold_request = 1'b0;
			end
			stall = $urandom_range(0, 7);
			if ($urandom_range(0, 3) == 0)
				stall = 0;
			if (stall != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!rsp_ch.valid);
			if (pending_verdicts.size() == 0) begin
				$error("response with no request outstanding");
				errors++;
			end else begin
				want = pending_verdicts.pop_front();
				if (rsp_ch.accepted !== want.accepted) begin
					$error("accepted: expected %0d, got %0d", want.accepted, rsp_ch.accepted);
					errors++;
				end
				if (rsp_ch.peak_overlap !== want.peak_overlap) begin
					$error("peak_overlap: expected %0d, got %0d",
						want.peak_overlap, rsp_ch.peak_overlap);
					errors++;
				end
			end
		end
	end

	// Watchdog: counts cycles in which neither channel moves a request. The
	// limit covers the clearing pass, a full-width update and the hold-off.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_MAX) begin
				$display("tb: done, errors");
				$finish;
			end
		end
	end

	row_t directed [] = '{
		// Empty intervals, including ones that only become empty once clamped.
		'{1'b0, 4'd0, 11'd0,    11'd0,    1'b1, '{1'b1, 4'd0}},
		'{1'b0, 4'd0, 11'd5,    11'd3,    1'b1, '{1'b1, 4'd0}},
		'{1'b0, 4'd0, 11'd2047, 11'd2047, 1'b1, '{1'b1, 4'd0}},
		'{1'b0, 4'd0, 11'd1024, 11'd2047, 1'b1, '{1'b1, 4'd0}},
		// Whole range twice, the second time with the end clamped.
		'{1'b0, 4'd0, 11'd0,    11'd1024, 1'b1, '{1'b1, 4'd0}},
		'{1'b0, 4'd0, 11'd0,    11'd2047, 1'b1, '{1'b1, 4'd1}},
		// Reset capacity of two is now reached everywhere.
		'{1'b0, 4'd0, 11'd0,    11'd1,    1'b1, '{1'b0, 4'd2}},
		'{1'b0, 4'd0, 11'd1023, 11'd1024, 1'b1, '{1'b0, 4'd2}},
		'{1'b0, 4'd0, 11'h2AA,  11'h555,  1'b1, '{1'b0, 4'd2}},
		'{1'b0, 4'd0, 11'h555,  11'h7FF,  1'b0, '0},
		// Highest capacity: layers build up.
		'{1'b1, 4'd15, 11'd0,   11'd0,    1'b0, '0},
		'{1'b0, 4'd0, 11'd0,    11'd1024, 1'b1, '{1'b1, 4'd2}},
		'{1'b0, 4'd0, 11'd10,   11'd20,   1'b1, '{1'b1, 4'd3}},
		'{1'b0, 4'd0, 11'd15,   11'd30,   1'b0, '0},
		'{1'b0, 4'd0, 11'd12,   11'd13,   1'b0, '0},
		// Capacity zero refuses every non-empty interval.
		'{1'b1, 4'd0, 11'd0,    11'd0,    1'b0, '0},
		'{1'b0, 4'd0, 11'd100,  11'd200,  1'b1, '{1'b0, 4'd3}},
		'{1'b0, 4'd0, 11'd3,    11'd3,    1'b1, '{1'b1, 4'd0}},
		// Capacity lowered below the present load keeps the counts.
		'{1'b1, 4'd1, 11'd0,    11'd0,    1'b0, '0},
		'{1'b0, 4'd0, 11'd0,    11'd1,    1'b1, '{1'b0, 4'd3}},
		'{1'b0, 4'd0, 11'd14,   11'd16,   1'b0, '0}
	};

	int caps [] = '{15, 1, 7, 0, 3, 15, 10, 2};

	initial begin
		errors       = 0;
		hold_request = 1'b0;
		cap_now      = CAPACITY_RESET;
		foreach (slot_load[i])
			slot_load[i] = '0;
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		req_ch.valid       = 1'b0;
		req_ch.range_start = '0;
		req_ch.range_end   = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// The block is busy clearing its store after reset; the handshake
		// simply waits for it.
		foreach (directed[i]) begin
			if (directed[i].set_cap) begin
				drain();
				apb_write(CAPACITY_ADDR, PDATA_W'(directed[i].cap));
			end else begin
				send_request(directed[i].range_start, directed[i].range_end,
					directed[i].fixed, directed[i].outcome);
			end
		end

		// A write to an unmapped address must leave the capacity at one.
		drain();
		apb_write(UNMAPPED_ADDR, PDATA_W'(15));
		send_request(11'd40, 11'd41, 1'b0, '0);
		send_request(11'd0, 11'd5, 1'b0, '0);

		// Random phases, each under its own capacity. The long hold-off on the
		// response side lands in the middle of one phase.
		foreach (caps[p]) begin
			drain();
			apb_write(CAPACITY_ADDR, PDATA_W'(caps[p]));
			for (int n = 0; n < 91; n++) begin
				if (p == 2 && n == 30)
					hold_request = 1'b1;
				random_request();
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule
`default_nettype wire
